FILE: hdl/tempo_delay_with_rotation_assert.svh
// assertion macros shared by the delay line rtl
`ifndef TEMPO_DELAY_WITH_ROTATION_ASSERT_SVH
`define TEMPO_DELAY_WITH_ROTATION_ASSERT_SVH

// same-cycle implication, checked at every rising clk outside reset
`define TDWR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising clk outside reset
`define TDWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tdwr_pkg.sv
// shared types, constants and the quarter-wave sine table of the delay line
`default_nettype none

package tdwr_pkg;

  localparam int SPQ_W = 25;
  localparam logic [SPQ_W-1:0] SPQ_RESET = 25'd6144000;
  localparam int QN_W = 16;
  localparam int IO_W = 16;
  localparam int ANG_W = 16;
  localparam int TRIG_W = 17;

  // register index, taken from paddr bit 2
  localparam logic REG_SPQ = 1'b0;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DELAY,
    S_POS,
    S_RDL,
    S_RDR,
    S_INTR,
    S_SUMR,
    S_ROT,
    S_SAT,
    S_FB,
    S_WR
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic load_item;
    logic calc_delay;
    logic calc_pos;
    logic rd_left;
    logic rd_right;
    logic interp_left;
    logic interp_right;
    logic sum_left;
    logic sum_right;
    logic rotate;
    logic saturate;
    logic feedback;
    logic load_out;
    logic store;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } stat_t;

  // quarter-wave sine, scale 32768; entries past the end hold the peak
  function automatic logic [15:0] quarter_sine(input logic [5:0] idx);
    logic [15:0] v;
    unique case (idx)
      6'd0:  v = 16'd0;
      6'd1:  v = 16'd1608;
      6'd2:  v = 16'd3212;
      6'd3:  v = 16'd4808;
      6'd4:  v = 16'd6393;
      6'd5:  v = 16'd7962;
      6'd6:  v = 16'd9512;
      6'd7:  v = 16'd11039;
      6'd8:  v = 16'd12540;
      6'd9:  v = 16'd14010;
      6'd10: v = 16'd15447;
      6'd11: v = 16'd16846;
      6'd12: v = 16'd18205;
      6'd13: v = 16'd19520;
      6'd14: v = 16'd20788;
      6'd15: v = 16'd22006;
      6'd16: v = 16'd23170;
      6'd17: v = 16'd24279;
      6'd18: v = 16'd25330;
      6'd19: v = 16'd26320;
      6'd20: v = 16'd27246;
      6'd21: v = 16'd28106;
      6'd22: v = 16'd28899;
      6'd23: v = 16'd29622;
      6'd24: v = 16'd30274;
      6'd25: v = 16'd30853;
      6'd26: v = 16'd31357;
      6'd27: v = 16'd31786;
      6'd28: v = 16'd32138;
      6'd29: v = 16'd32413;
      6'd30: v = 16'd32610;
      6'd31: v = 16'd32729;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tempo_delay_with_rotation.sv
// top level of the tempo-synced stereo delay line with feedback and rotation
//
// usage
// - input channel: in_valid / in_stall; an item is taken at a rising clk with
//   in_valid high and in_stall low. it carries one stereo sample, a delay per
//   channel in quarter notes, a feedback gain and a rotation angle
// - output channel: out_valid / out_stall; one result item per input item,
//   the rotated delayed pair, held unchanged while out_stall is high
// - apb port: one register, samples_per_quarter at byte address 0; it is to be
//   written only while no item is in flight, which the block does not enforce;
//   pready is always high
// - the result shows on out_valid after the feedback step loads it; a new item
//   is taken only once the last one has run the ten-step sequence of the
//   controller around the two-read-port ring buffer and one shared interpolation unit
// - a stalled output only blocks the block when the next result is ready to
//   load; a new item is accepted while the previous result still waits
// - reset: rst is synchronous; afterwards the ring buffer is cleared one entry
//   a cycle, every entry in turn, with in_stall high; the apb port works then
`default_nettype none

module tempo_delay_with_rotation #(
  parameter int DELAY_DEPTH = 32768
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [tdwr_pkg::IO_W-1:0]  in_left,
  input  logic signed [tdwr_pkg::IO_W-1:0]  in_right,
  input  logic [tdwr_pkg::QN_W-1:0]         delay_left_qn,
  input  logic [tdwr_pkg::QN_W-1:0]         delay_right_qn,
  input  logic signed [tdwr_pkg::IO_W-1:0]  feedback_gain,
  input  logic [tdwr_pkg::ANG_W-1:0]        rotate_turns,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tdwr_pkg::IO_W-1:0]  out_left,
  output logic signed [tdwr_pkg::IO_W-1:0]  out_right
);

  // samples per quarter note, 8 fraction bits
  logic [tdwr_pkg::SPQ_W-1:0] spq;
  logic                       cfg_wr;

  tdwr_pkg::cmd_t  cmd;
  tdwr_pkg::stat_t status;

  assign pready = 1'b1;
  // byte lanes within the word are not decoded; bit 2 picks the register
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tdwr_pkg::REG_SPQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      spq <= tdwr_pkg::SPQ_RESET;
    end else if (cfg_wr) begin
      spq <= pwdata[tdwr_pkg::SPQ_W-1:0];
    end
  end

  // read back: unused addresses read as zero
  assign prdata = (paddr[2] == tdwr_pkg::REG_SPQ) ? 32'(spq) : 32'd0;

  // sequencer
  tdwr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .status  (status),
    .in_stall(in_stall),
    .cmd     (cmd)
  );

  // arithmetic, ring buffer and output register
  tdwr_datapath #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .spq           (spq),
    .in_left       (in_left),
    .in_right      (in_right),
    .delay_left_qn (delay_left_qn),
    .delay_right_qn(delay_right_qn),
    .feedback_gain (feedback_gain),
    .rotate_turns  (rotate_turns),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left      (out_left),
    .out_right     (out_right)
  );

endmodule

`default_nettype wire

FILE: hdl/tdwr_ram.sv
// generic ram, one write port and two registered read ports
`default_nettype none

module tdwr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tdwr_ctrl.sv
// sequencer of the delay line: clearing pass and per-item step order
`default_nettype none
`include "tempo_delay_with_rotation_assert.svh"

module tdwr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  tdwr_pkg::stat_t status,
  output logic            in_stall,
  output tdwr_pkg::cmd_t  cmd
);

  tdwr_pkg::state_t state;
  tdwr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdwr_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      tdwr_pkg::S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = tdwr_pkg::S_IDLE;
        end
      end
      tdwr_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = tdwr_pkg::S_DELAY;
        end
      end
      tdwr_pkg::S_DELAY: begin
        cmd.calc_delay = 1'b1;
        state_next     = tdwr_pkg::S_POS;
      end
      tdwr_pkg::S_POS: begin
        cmd.calc_pos = 1'b1;
        state_next   = tdwr_pkg::S_RDL;
      end
      tdwr_pkg::S_RDL: begin
        cmd.rd_left = 1'b1;
        state_next  = tdwr_pkg::S_RDR;
      end
      tdwr_pkg::S_RDR: begin
        cmd.rd_right    = 1'b1;
        cmd.interp_left = 1'b1;
        state_next      = tdwr_pkg::S_INTR;
      end
      tdwr_pkg::S_INTR: begin
        cmd.interp_right = 1'b1;
        cmd.sum_left     = 1'b1;
        state_next       = tdwr_pkg::S_SUMR;
      end
      tdwr_pkg::S_SUMR: begin
        cmd.sum_right = 1'b1;
        state_next    = tdwr_pkg::S_ROT;
      end
      tdwr_pkg::S_ROT: begin
        cmd.rotate = 1'b1;
        state_next = tdwr_pkg::S_SAT;
      end
      tdwr_pkg::S_SAT: begin
        cmd.saturate = 1'b1;
        state_next   = tdwr_pkg::S_FB;
      end
      tdwr_pkg::S_FB: begin
        cmd.feedback = 1'b1;
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = tdwr_pkg::S_WR;
        end
      end
      tdwr_pkg::S_WR: begin
        cmd.store  = 1'b1;
        state_next = tdwr_pkg::S_IDLE;
      end
      default: begin
        state_next = tdwr_pkg::S_IDLE;
      end
    endcase
  end

  `TDWR_ASSERT_NEXT(a_clear_holds, (state == tdwr_pkg::S_CLEAR) && !status.clear_last, state == tdwr_pkg::S_CLEAR, "clearing pass left early")
  `TDWR_ASSERT_NEXT(a_accept_starts, (state == tdwr_pkg::S_IDLE) && in_valid, state == tdwr_pkg::S_DELAY, "accepted item did not start")
  `TDWR_ASSERT_NEXT(a_fb_waits, (state == tdwr_pkg::S_FB) && !status.out_free, state == tdwr_pkg::S_FB, "result step moved on while output busy")

endmodule

`default_nettype wire

FILE: hdl/tdwr_datapath.sv
// datapath: delay math, ring buffer, interpolation, rotation and feedback
`default_nettype none
`include "tempo_delay_with_rotation_assert.svh"

module tdwr_datapath #(
  parameter int DELAY_DEPTH = 32768
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tdwr_pkg::cmd_t                    cmd,
  output tdwr_pkg::stat_t                   status,
  input  logic [tdwr_pkg::SPQ_W-1:0]        spq,
  input  logic signed [tdwr_pkg::IO_W-1:0]  in_left,
  input  logic signed [tdwr_pkg::IO_W-1:0]  in_right,
  input  logic [tdwr_pkg::QN_W-1:0]         delay_left_qn,
  input  logic [tdwr_pkg::QN_W-1:0]         delay_right_qn,
  input  logic signed [tdwr_pkg::IO_W-1:0]  feedback_gain,
  input  logic [tdwr_pkg::ANG_W-1:0]        rotate_turns,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tdwr_pkg::IO_W-1:0]  out_left,
  output logic signed [tdwr_pkg::IO_W-1:0]  out_right
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int PW = AW + 8;
  localparam int SB = tdwr_pkg::IO_W;
  localparam int MW = 2 * SB;
  localparam int PRW = tdwr_pkg::SPQ_W + tdwr_pkg::QN_W;
  localparam int DW = PRW - 12;
  localparam int TW = tdwr_pkg::TRIG_W;
  localparam int WW = SB + 18;
  localparam logic signed [SB-1:0] SB_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SB_MIN = {1'b1, {(SB-1){1'b0}}};

  function automatic logic signed [SB-1:0] sat_s(input logic signed [WW-1:0] v);
    logic signed [SB-1:0] r;
    if (v > WW'(SB_MAX)) begin
      r = SB_MAX;
    end else if (v < WW'(SB_MIN)) begin
      r = SB_MIN;
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  // item registers
  logic signed [tdwr_pkg::IO_W-1:0] in_l_q, in_r_q, fb_q;
  logic [tdwr_pkg::QN_W-1:0]        qn_l_q, qn_r_q;
  logic [tdwr_pkg::ANG_W-1:0]       ang_q;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      in_l_q <= in_left;
      in_r_q <= in_right;
      fb_q   <= feedback_gain;
      qn_l_q <= delay_left_qn;
      qn_r_q <= delay_right_qn;
      ang_q  <= rotate_turns;
    end
  end

  // delay in samples, 8 fraction bits
  logic [PRW-1:0] prod_dl, prod_dr;
  logic [DW-1:0]  delay_l, delay_r;

  assign prod_dl = spq * qn_l_q;
  assign prod_dr = spq * qn_r_q;

  // sine (k = 0) and cosine (k = 1) from the quarter table
  logic [tdwr_pkg::ANG_W-1:0] angle [2];
  logic [14:0] qx    [2];
  logic [5:0]  qi    [2];
  logic [8:0]  qf    [2];
  logic [15:0] tbase [2];
  logic [15:0] tnext [2];
  logic [10:0] tdiff [2];
  logic [19:0] tprod [2];
  logic [15:0] sin_base [2];
  logic [10:0] sin_frac [2];
  logic        sin_neg  [2];
  logic [15:0] mag      [2];
  logic signed [TW-1:0] trig [2];

  always_comb begin
    angle[0] = ang_q;
    angle[1] = ang_q + 16'd16384;
    for (int k = 0; k < 2; k++) begin
      qx[k]    = angle[k][14] ? (15'd16384 - {1'b0, angle[k][13:0]})
                              : {1'b0, angle[k][13:0]};
      qi[k]    = qx[k][14:9];
      qf[k]    = qx[k][8:0];
      tbase[k] = tdwr_pkg::quarter_sine(qi[k]);
      tnext[k] = tdwr_pkg::quarter_sine(qi[k] + 6'd1);
      tdiff[k] = 11'(tnext[k] - tbase[k]);
      tprod[k] = tdiff[k] * qf[k];
      mag[k]   = sin_base[k] + {5'b0, sin_frac[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_delay) begin
      delay_l <= prod_dl[PRW-1:12];
      delay_r <= prod_dr[PRW-1:12];
      for (int k = 0; k < 2; k++) begin
        sin_base[k] <= tbase[k];
        sin_frac[k] <= tprod[k][19:9];
        sin_neg[k]  <= angle[k][15];
      end
    end
  end

  // read positions
  logic [AW-1:0] write_index;
  logic [PW-1:0] pos_l, pos_r;
  logic [AW-1:0] idx_l, idx_r;
  logic [7:0]    frac_l, frac_r;

  assign pos_l = {write_index, 8'h00} - delay_l[PW-1:0];
  assign pos_r = {write_index, 8'h00} - delay_r[PW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.calc_pos) begin
      idx_l  <= pos_l[PW-1:8];
      idx_r  <= pos_r[PW-1:8];
      frac_l <= pos_l[7:0];
      frac_r <= pos_r[7:0];
      for (int k = 0; k < 2; k++) begin
        trig[k] <= sin_neg[k] ? -$signed({1'b0, mag[k]}) : $signed({1'b0, mag[k]});
      end
    end
  end

  // ring buffer, entry = {left, right}
  logic [AW-1:0] clear_count;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [MW-1:0] rdata_a, rdata_b;
  logic signed [SB-1:0] st_l, st_r;

  assign ram_we    = cmd.store | cmd.clear_wr;
  assign ram_waddr = cmd.clear_wr ? clear_count : write_index;
  assign ram_wdata = cmd.clear_wr ? '0 : {st_l, st_r};
  assign ram_raddr = cmd.rd_left ? idx_l : idx_r;

  tdwr_ram #(
    .WIDTH(MW),
    .DEPTH(DELAY_DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (cmd.rd_left | cmd.rd_right),
    .raddr_a(ram_raddr),
    .raddr_b(ram_raddr + 1'b1),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_count <= '0;
      write_index <= '0;
    end else begin
      if (cmd.clear_wr) begin
        clear_count <= clear_count + 1'b1;
      end
      if (cmd.store) begin
        write_index <= write_index + 1'b1;
      end
    end
  end

  assign status.clear_last = (clear_count == '1);

  // shared interpolation: a*256 + (b - a)*f, one channel per cycle
  logic signed [SB-1:0]   ip_a, ip_b;
  logic signed [SB:0]     ip_d;
  logic [7:0]             ip_f;
  logic signed [SB+9:0]   ip_p;
  logic signed [SB-1:0]   base_l, base_r;
  logic signed [SB+9:0]   iprod_l, iprod_r;

  always_comb begin
    ip_a = cmd.interp_right ? rdata_a[SB-1:0] : rdata_a[MW-1:SB];
    ip_b = cmd.interp_right ? rdata_b[SB-1:0] : rdata_b[MW-1:SB];
    ip_f = cmd.interp_right ? frac_r : frac_l;
    ip_d = (SB+1)'(ip_b) - (SB+1)'(ip_a);
    ip_p = ip_d * $signed({1'b0, ip_f});
  end

  always_ff @(posedge clk) begin
    if (cmd.interp_left) begin
      base_l  <= ip_a;
      iprod_l <= ip_p;
    end
    if (cmd.interp_right) begin
      base_r  <= ip_a;
      iprod_r <= ip_p;
    end
  end

  // floor of the interpolated sum; the product's low byte drops out
  logic signed [SB-1:0] sm_a;
  logic signed [SB+9:0] sm_p;
  logic signed [SB+1:0] sm_v;
  logic signed [SB-1:0] dl, dr;

  always_comb begin
    sm_a = cmd.sum_right ? base_r : base_l;
    sm_p = cmd.sum_right ? iprod_r : iprod_l;
    sm_v = (SB+2)'(sm_a) + $signed(sm_p[SB+9:8]);
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_left) begin
      dl <= sm_v[SB-1:0];
    end
    if (cmd.sum_right) begin
      dr <= sm_v[SB-1:0];
    end
  end

  // rotation products
  logic signed [SB+TW-1:0] m_lc, m_rs, m_ls, m_rc;

  always_ff @(posedge clk) begin
    if (cmd.rotate) begin
      m_lc <= dl * trig[1];
      m_rs <= dr * trig[0];
      m_ls <= dl * trig[0];
      m_rc <= dr * trig[1];
    end
  end

  logic signed [SB+TW:0] rot_l, rot_r;
  logic signed [SB-1:0]  ol_q, or_q;

  assign rot_l = (SB+TW+1)'(m_lc) - (SB+TW+1)'(m_rs);
  assign rot_r = (SB+TW+1)'(m_ls) + (SB+TW+1)'(m_rc);

  always_ff @(posedge clk) begin
    if (cmd.saturate) begin
      ol_q <= sat_s(WW'($signed(rot_l[SB+TW:15])));
      or_q <= sat_s(WW'($signed(rot_r[SB+TW:15])));
    end
  end

  // feedback products and stored words
  logic signed [SB+15:0] fbp_l, fbp_r;

  always_ff @(posedge clk) begin
    if (cmd.feedback) begin
      fbp_l <= ol_q * fb_q;
      fbp_r <= or_q * fb_q;
    end
  end

  assign st_l = sat_s(WW'(in_l_q) + WW'($signed(fbp_l[SB+15:15])));
  assign st_r = sat_s(WW'(in_r_q) + WW'($signed(fbp_r[SB+15:15])));

  // output register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_left  <= ol_q;
      out_right <= or_q;
    end
  end

  `TDWR_ASSERT_NEXT(a_wi_advance, cmd.store, write_index == $past(write_index) + 1'b1, "write index did not advance")
  `TDWR_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid || !out_stall, "result overwritten while stalled")
  `TDWR_ASSERT_NEXT(a_clear_walk, cmd.clear_wr, clear_count == $past(clear_count) + 1'b1, "clearing pass skipped an entry")

endmodule

`default_nettype wire
